[rtl/core/spmf_pkg.sv]
// Shared constants, codes and types of the strict priority multi-level queue.
package spmf_pkg;

    localparam int NUM_LEVELS_DEF  = 3;
    localparam int LEVEL_DEPTH_DEF = 16;

    localparam int OP_W     = 1;
    localparam int LEVEL_W  = 2;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;      // latch the accepted item
        logic exec;      // run the enqueue or dequeue
        logic load_out;  // move the result into the output register
    } t_cmd;

endpackage

[rtl/core/spmf_ctrl.sv]
// Controller state machine: input/output handshakes and datapath sequencing.
module spmf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spmf_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load_ok;

    assign load_ok = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (load_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_ok) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.take     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.load_out = load_ok;

endmodule

[rtl/core/spmf_dp.sv]
// Datapath: item register, per-level pointers and counts, byte storage, result register.
module spmf_dp #(
    parameter int NUM_LEVELS  = spmf_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spmf_pkg::t_cmd                i_cmd,
    input  logic [spmf_pkg::OP_W-1:0]     i_op,
    input  logic [spmf_pkg::LEVEL_W-1:0]  i_level,
    input  logic [spmf_pkg::DATA_W-1:0]   i_data_in,
    output logic [spmf_pkg::DATA_W-1:0]   o_data_out,
    output logic [spmf_pkg::LEVEL_W-1:0]  o_served_level,
    output logic [spmf_pkg::STATUS_W-1:0] o_status
);

    localparam int LW = $clog2(NUM_LEVELS);
    localparam int PW = $clog2(LEVEL_DEPTH);
    localparam int CW = $clog2(LEVEL_DEPTH + 1);

    // Accepted item
    logic [spmf_pkg::OP_W-1:0]     r_op;
    logic [spmf_pkg::LEVEL_W-1:0]  r_level;
    logic [spmf_pkg::DATA_W-1:0]   r_data;

    // Per-level FIFO control
    logic [PW-1:0] r_head  [NUM_LEVELS];
    logic [PW-1:0] r_tail  [NUM_LEVELS];
    logic [CW-1:0] r_count [NUM_LEVELS];

    logic [spmf_pkg::DATA_W-1:0] mem [NUM_LEVELS][LEVEL_DEPTH];
    logic [spmf_pkg::DATA_W-1:0] r_rd_data;

    // Result of the executed item
    logic                          r_res_rd;
    logic [spmf_pkg::LEVEL_W-1:0]  r_res_level;
    spmf_pkg::t_status             r_res_status;

    logic [spmf_pkg::DATA_W-1:0]   r_data_out;
    logic [spmf_pkg::LEVEL_W-1:0]  r_served_level;
    spmf_pkg::t_status             r_status;

    logic [LW-1:0] lvl_idx;
    logic          lvl_ok;
    logic          enq_full;
    logic          is_deq;
    logic          do_wr;
    logic          do_rd;
    logic          found;
    logic [LW-1:0] pick;

    assign is_deq   = (r_op == spmf_pkg::OP_DEQ);
    assign lvl_idx  = LW'(r_level);
    assign lvl_ok   = (32'(r_level) < NUM_LEVELS);
    assign enq_full = !lvl_ok || (r_count[lvl_idx] == CW'(LEVEL_DEPTH));
    assign do_wr    = i_cmd.exec && !is_deq && !enq_full;
    assign do_rd    = i_cmd.exec && is_deq && found;

    // Lowest-numbered non-empty level wins
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
            if (r_count[k] != '0) begin
                found = 1'b1;
                pick  = LW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op    <= i_op;
            r_level <= i_level;
            r_data  <= i_data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            if (do_wr) begin
                r_tail[lvl_idx]  <= (r_tail[lvl_idx] == PW'(LEVEL_DEPTH - 1)) ? '0
                                    : r_tail[lvl_idx] + 1'b1;
                r_count[lvl_idx] <= r_count[lvl_idx] + 1'b1;
            end
            if (do_rd) begin
                r_head[pick]  <= (r_head[pick] == PW'(LEVEL_DEPTH - 1)) ? '0
                                 : r_head[pick] + 1'b1;
                r_count[pick] <= r_count[pick] - 1'b1;
            end
        end
    end

    // Byte storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            mem[lvl_idx][r_tail[lvl_idx]] <= r_data;
        end
        if (do_rd) begin
            r_rd_data <= mem[pick][r_head[pick]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_rd <= is_deq && found;
            if (!is_deq) begin
                r_res_level  <= r_level;
                r_res_status <= enq_full ? spmf_pkg::ST_FULL : spmf_pkg::ST_OK;
            end else begin
                r_res_level  <= found ? spmf_pkg::LEVEL_W'(pick) : '0;
                r_res_status <= found ? spmf_pkg::ST_OK : spmf_pkg::ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_data_out     <= r_res_rd ? r_rd_data : '0;
            r_served_level <= r_res_level;
            r_status       <= r_res_status;
        end
    end

    assign o_data_out     = r_data_out;
    assign o_served_level = r_served_level;
    assign o_status       = r_status;

endmodule

[rtl/core/strict_priority_multi_fifo.sv]
// Top level of the strict priority multi-level byte queue.
// A result is presented once its item has passed the execute and load-result states.
// A new item is taken only in the idle state, so the block does not accept one until the
//   previous item has been executed and its result loaded, which waits on a full output.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) empties every level; storage is not cleared.
module strict_priority_multi_fifo #(
    parameter int NUM_LEVELS  = spmf_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [spmf_pkg::OP_W-1:0]     i_op,
    input  logic [spmf_pkg::LEVEL_W-1:0]  i_level,
    input  logic [spmf_pkg::DATA_W-1:0]   i_data_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [spmf_pkg::DATA_W-1:0]   o_data_out,
    output logic [spmf_pkg::LEVEL_W-1:0]  o_served_level,
    output logic [spmf_pkg::STATUS_W-1:0] o_status
);

    spmf_pkg::t_cmd cmd;

    spmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    spmf_dp #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_op),
        .i_level        (i_level),
        .i_data_in      (i_data_in),
        .o_data_out     (o_data_out),
        .o_served_level (o_served_level),
        .o_status       (o_status)
    );

endmodule
